// ----- rtl/core/qts_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the two-stack queue unit.
// No dependencies; every other file in rtl/core but qts_ram uses it by scoped names.
package qts_pkg;

    // Fixed payload widths of the request and response channels
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // Operation codes on the request channel
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // Response status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // One request as captured from the input channel
    typedef struct packed {
        logic               func;
        logic [VALUE_W-1:0] enqueue_value;
    } item_t;

    // One finished result handed from the sequencer to the output register
    typedef struct packed {
        logic [VALUE_W-1:0]  dequeue_value;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// ----- rtl/core/qts_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the two-stack queue unit.
// Depends on qts_pkg for payload widths.
interface qts_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [qts_pkg::VALUE_W-1:0] enqueue_value;

    modport source (output valid, output func, output enqueue_value, input ready);
    modport sink   (input valid, input func, input enqueue_value, output ready);
endinterface

interface qts_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [qts_pkg::VALUE_W-1:0]  dequeue_value;
    logic [qts_pkg::STATUS_W-1:0] status;

    modport source (output valid, output dequeue_value, output status, input ready);
    modport sink   (input valid, input dequeue_value, input status, output ready);
endinterface

// ----- rtl/core/qts_ram.sv -----
`timescale 1ns / 1ps
// Single-port-write, single-port-read stack memory with registered read data.
// No package dependencies.
module qts_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/qts_seq.sv -----
`timescale 1ns / 1ps
// Sequencer of the two-stack queue: stack counters, request handling and the
// one-entry-per-cycle refill of the output stack. Depends on qts_pkg.
module qts_seq #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  qts_pkg::item_t           item,
    output logic                     idle,
    output logic                     done,
    input  logic                     take,
    output qts_pkg::result_t         result,
    output logic                     in_we,
    output logic [$clog2(DEPTH)-1:0] in_waddr,
    output logic [DATA_WIDTH-1:0]    in_wdata,
    output logic                     in_re,
    output logic [$clog2(DEPTH)-1:0] in_raddr,
    input  logic [DATA_WIDTH-1:0]    in_rdata,
    output logic                     out_we,
    output logic [$clog2(DEPTH)-1:0] out_waddr,
    output logic [DATA_WIDTH-1:0]    out_wdata,
    output logic                     out_re,
    output logic [$clog2(DEPTH)-1:0] out_raddr,
    input  logic [DATA_WIDTH-1:0]    out_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_XFER = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [CW-1:0]                 in_cnt_reg, in_cnt_next;
    logic [CW-1:0]                 out_cnt_reg, out_cnt_next;
    logic                          pend_reg, pend_next;
    logic                          func_reg, func_next;
    logic [DATA_WIDTH-1:0]         data_reg, data_next;
    logic [qts_pkg::VALUE_W-1:0]   value_reg, value_next;
    logic [qts_pkg::STATUS_W-1:0]  status_reg, status_next;

    logic [CW-1:0] in_last;
    logic [CW-1:0] out_last;
    logic [63:0]   enq_wide;
    logic [63:0]   rd_wide;

    // Width adaption between the 32-bit channels and DATA_WIDTH storage
    assign enq_wide = 64'(item.enqueue_value);
    assign rd_wide  = 64'(out_rdata);

    // Stack tops
    assign in_last  = in_cnt_reg - CNT_ONE;
    assign out_last = out_cnt_reg - CNT_ONE;

    assign in_waddr  = in_cnt_reg[AW-1:0];
    assign in_raddr  = in_last[AW-1:0];
    assign in_wdata  = data_reg;
    assign out_waddr = out_cnt_reg[AW-1:0];
    assign out_raddr = out_last[AW-1:0];
    assign out_wdata = in_rdata;

    assign idle                 = (state_reg == S_IDLE);
    assign done                 = (state_reg == S_DONE);
    assign result.dequeue_value = value_reg;
    assign result.status        = status_reg;

    // Next-state and datapath control
    always_comb
    begin
        state_next   = state_reg;
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        pend_next    = pend_reg;
        func_next    = func_reg;
        data_next    = data_reg;
        value_next   = value_reg;
        status_next  = status_reg;
        in_we        = 1'b0;
        in_re        = 1'b0;
        out_we       = 1'b0;
        out_re       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                // Capture the request
                if (start)
                begin
                    func_next  = item.func;
                    data_next  = enq_wide[DATA_WIDTH-1:0];
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                value_next = '0;
                if (func_reg == qts_pkg::FUNC_ENQ)
                begin
                    // Push, or reject when the input stack is full
                    if (in_cnt_reg == CNT_FULL)
                    begin
                        status_next = qts_pkg::ST_FULL;
                    end
                    else
                    begin
                        in_we       = 1'b1;
                        in_cnt_next = in_cnt_reg + CNT_ONE;
                        status_next = qts_pkg::ST_OK;
                    end
                    state_next = S_DONE;
                end
                else if (out_cnt_reg != '0)
                begin
                    // Pop the output stack
                    out_re       = 1'b1;
                    out_cnt_next = out_last;
                    state_next   = S_READ;
                end
                else if (in_cnt_reg != '0)
                begin
                    state_next = S_XFER;
                end
                else
                begin
                    status_next = qts_pkg::ST_EMPTY;
                    state_next  = S_DONE;
                end
            end
            S_XFER:
            begin
                // Read the input stack top, write last cycle's entry
                if (in_cnt_reg != '0)
                begin
                    in_re       = 1'b1;
                    in_cnt_next = in_last;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    out_we       = 1'b1;
                    out_cnt_next = out_cnt_reg + CNT_ONE;
                end
                if ((in_cnt_reg == '0) && !pend_reg)
                begin
                    state_next = S_EXEC;
                end
            end
            S_READ:
            begin
                value_next  = rd_wide[qts_pkg::VALUE_W-1:0];
                status_next = qts_pkg::ST_OK;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register takes the result
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
            pend_reg    <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        data_reg   <= data_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

endmodule

// ----- rtl/core/queue_from_two_stacks_unit.sv -----
`timescale 1ns / 1ps
// Top level of the two-stack queue: two stack memories, the sequencer and
// the response register. Depends on qts_pkg, qts_if, qts_ram and qts_seq.
//
// A FIFO queue built from two stacks of DEPTH entries, DATA_WIDTH bits each.
// One request is worked at a time; req.ready is high only while the
// sequencer is idle, and each request gives exactly one response. The
// response register lets a new request in while the previous result waits.
// From the accepted request, an enqueue or a rejected dequeue passes the
// execute and done states before the response register loads; a dequeue
// served from the output stack adds a read state for its registered memory
// read. The sequencer turns idle as the response loads, so the next request
// can be accepted once the result is in the response register. A dequeue
// that finds the output stack empty first moves all n entries of the input
// stack across, one per cycle through the single read port of the input
// stack memory. Every element is moved at most once. An enqueue onto a full
// input stack answers status 1; a dequeue with both stacks empty answers
// status 2; dequeue_value is zero unless a dequeue succeeds. No memory
// clearing is needed after reset.
module queue_from_two_stacks_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    qts_req_if.sink     req,
    qts_rsp_if.source   rsp
);

    localparam int AW = $clog2(DEPTH);

    qts_pkg::item_t   item;
    qts_pkg::result_t result;
    logic             start;
    logic             idle;
    logic             done;
    logic             take;
    logic             load;

    logic                  in_we, in_re, out_we, out_re;
    logic [AW-1:0]         in_waddr, in_raddr, out_waddr, out_raddr;
    logic [DATA_WIDTH-1:0] in_wdata, in_rdata, out_wdata, out_rdata;

    logic                         rsp_valid_reg, rsp_valid_next;
    logic [qts_pkg::VALUE_W-1:0]  rsp_value_reg;
    logic [qts_pkg::STATUS_W-1:0] rsp_status_reg;

    // Request side
    assign item.func          = req.func;
    assign item.enqueue_value = req.enqueue_value;
    assign req.ready          = idle;
    assign start              = req.valid && idle;

    // Response register: load when empty or being drained
    assign take = !rsp_valid_reg || rsp.ready;
    assign load = done && take;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_value_reg  <= result.dequeue_value;
            rsp_status_reg <= result.status;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.dequeue_value = rsp_value_reg;
    assign rsp.status        = rsp_status_reg;

    // Input stack memory
    qts_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_in_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_waddr),
        .wdata (in_wdata),
        .re    (in_re),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    // Output stack memory
    qts_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_out_ram (
        .clk   (clk),
        .we    (out_we),
        .waddr (out_waddr),
        .wdata (out_wdata),
        .re    (out_re),
        .raddr (out_raddr),
        .rdata (out_rdata)
    );

    // Sequencer
    qts_seq #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .idle      (idle),
        .done      (done),
        .take      (take),
        .result    (result),
        .in_we     (in_we),
        .in_waddr  (in_waddr),
        .in_wdata  (in_wdata),
        .in_re     (in_re),
        .in_raddr  (in_raddr),
        .in_rdata  (in_rdata),
        .out_we    (out_we),
        .out_waddr (out_waddr),
        .out_wdata (out_wdata),
        .out_re    (out_re),
        .out_raddr (out_raddr),
        .out_rdata (out_rdata)
    );

endmodule

// ----- rtl/core/qts_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the two-stack queue unit, bound to the top level.
// Depends on qts_pkg and queue_from_two_stacks_unit.
module qts_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [qts_pkg::VALUE_W-1:0]  rsp_dequeue_value,
    input logic [qts_pkg::STATUS_W-1:0] rsp_status
);

    // Hold a stalled response
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // Drop ready after an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request accepted while one is in work");

    // Produce no response in the cycle right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("response appeared too early");

    // Zero the value on every response whose status is not OK
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != qts_pkg::ST_OK) |-> rsp_dequeue_value == '0)
        else $error("rejected request returned a nonzero value");

endmodule

bind queue_from_two_stacks_unit qts_checker u_qts_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_dequeue_value (rsp.dequeue_value),
    .rsp_status        (rsp.status)
);

// ----- dv/tb_queue_from_two_stacks_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for queue_from_two_stacks_unit: directed table, then random requests,
// each response checked against the table's want_* values or a two-stack queue predictor. Depends on qts_pkg, qts_if.
module tb_queue_from_two_stacks_unit;

    localparam int QUEUE_DEPTH   = 16;
    localparam int RANDOM_ITEMS  = 700;
    localparam int CALM_TAIL     = 100;
    localparam int PAUSE_AT      = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int NUM_ROWS      = 14;

    // One row of directed stimulus; want_* is used only when has_want is set
    typedef struct {
        logic                         op;
        logic [qts_pkg::VALUE_W-1:0]  value;
        int                           reps;
        bit                           has_want;
        logic [qts_pkg::VALUE_W-1:0]  want_value;
        logic [qts_pkg::STATUS_W-1:0] want_status;
    } stim_row_t;

    logic clk;
    logic rst_n;

    qts_req_if req_ch ();
    qts_rsp_if rsp_ch ();

    queue_from_two_stacks_unit #(
        .DEPTH      (QUEUE_DEPTH),
        .DATA_WIDTH (qts_pkg::VALUE_W)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predictor state: both stacks and their fill levels
    logic [qts_pkg::VALUE_W-1:0] enq_stack_mem [QUEUE_DEPTH];
    logic [qts_pkg::VALUE_W-1:0] deq_stack_mem [QUEUE_DEPTH];
    int                          enq_depth;
    int                          deq_depth;

    qts_pkg::result_t pending_results [$];
    int               mismatch_count;
    int               quiet_cycles;
    bit               sender_gaps_on;
    bit               sink_gaps_on;
    int               stall_left;

    stim_row_t directed_rows [NUM_ROWS] = '{
        '{qts_pkg::FUNC_DEQ, 32'h0000_0000,  1, 1'b1, 32'h0, qts_pkg::ST_EMPTY},
        '{qts_pkg::FUNC_ENQ, 32'h0000_0000,  1, 1'b1, 32'h0, qts_pkg::ST_OK},
        '{qts_pkg::FUNC_ENQ, 32'hFFFF_FFFF,  1, 1'b1, 32'h0, qts_pkg::ST_OK},
        '{qts_pkg::FUNC_DEQ, 32'h0000_0000,  1, 1'b0, 32'h0, qts_pkg::ST_OK},
        '{qts_pkg::FUNC_ENQ, 32'h8000_0001,  1, 1'b1, 32'h0, qts_pkg::ST_OK},
        '{qts_pkg::FUNC_DEQ, 32'h0000_0000,  2, 1'b0, 32'h0, qts_pkg::ST_OK},
        '{qts_pkg::FUNC_DEQ, 32'h0000_0000,  1, 1'b1, 32'h0, qts_pkg::ST_EMPTY},
        '{qts_pkg::FUNC_ENQ, 32'h1000_0000, 16, 1'b1, 32'h0, qts_pkg::ST_OK},
        // input stack full while the output stack is empty
        '{qts_pkg::FUNC_ENQ, 32'hDEAD_BEEF,  1, 1'b1, 32'h0, qts_pkg::ST_FULL},
        '{qts_pkg::FUNC_DEQ, 32'h0000_0000,  1, 1'b0, 32'h0, qts_pkg::ST_OK},
        '{qts_pkg::FUNC_ENQ, 32'h2000_0000, 16, 1'b1, 32'h0, qts_pkg::ST_OK},
        '{qts_pkg::FUNC_ENQ, 32'h5A5A_5A5A,  1, 1'b1, 32'h0, qts_pkg::ST_FULL},
        '{qts_pkg::FUNC_DEQ, 32'hFFFF_FFFF, 32, 1'b0, 32'h0, qts_pkg::ST_OK},
        '{qts_pkg::FUNC_DEQ, 32'hFFFF_FFFF,  1, 1'b1, 32'h0, qts_pkg::ST_EMPTY}
    };

    // Apply one request to the predictor and return the response it must give
    function automatic qts_pkg::result_t next_queue_result(
        input logic                        op,
        input logic [qts_pkg::VALUE_W-1:0] value);
        qts_pkg::result_t res;
        res.dequeue_value = '0;
        res.status        = qts_pkg::ST_OK;
        if (op == qts_pkg::FUNC_ENQ)
        begin
            if (enq_depth >= QUEUE_DEPTH)
                res.status = qts_pkg::ST_FULL;
            else
            begin
                enq_stack_mem[enq_depth] = value;
                enq_depth++;
            end
        end
        else
        begin
            // refill the output stack, top first, only when it is empty
            if (deq_depth == 0)
            begin
                while (enq_depth > 0 && deq_depth < QUEUE_DEPTH)
                begin
                    enq_depth--;
                    deq_stack_mem[deq_depth] = enq_stack_mem[enq_depth];
                    deq_depth++;
                end
            end
            if (deq_depth == 0)
                res.status = qts_pkg::ST_EMPTY;
            else
            begin
                deq_depth--;
                res.dequeue_value = deq_stack_mem[deq_depth];
            end
        end
        return res;
    endfunction

    // Present one request, hold it until accepted, then log its expected response
    task automatic send_request(input logic op, input logic [qts_pkg::VALUE_W-1:0] value,
                                input bit has_want, input qts_pkg::result_t want);
        qts_pkg::result_t predicted;
        if (sender_gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.func          <= op;
        req_ch.enqueue_value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = next_queue_result(op, value);
        pending_results.push_back(has_want ? want : predicted);
    endtask

    function automatic logic [qts_pkg::VALUE_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Clock: 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Response ready, dropped in random stall bursts while sink gaps are on
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (sink_gaps_on && $urandom_range(0, 3) == 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // Check each accepted response against the oldest expectation
    always @(posedge clk)
    begin
        qts_pkg::result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected response: expected none, got value %h status %0d",
                         $time, rsp_ch.dequeue_value, rsp_ch.status);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.dequeue_value !== want.dequeue_value)
                begin
                    $display("%0t: dequeue_value mismatch: expected %h, got %h",
                             $time, want.dequeue_value, rsp_ch.dequeue_value);
                    mismatch_count++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, rsp_ch.status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: abort when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("tb_queue_from_two_stacks_unit: errors");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, random requests, drain, verdict
    initial
    begin
        qts_pkg::result_t want;
        int               mode;
        int               enq_pct;
        logic             op;
        stim_row_t        row;

        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.func          = qts_pkg::FUNC_ENQ;
        req_ch.enqueue_value = '0;
        rsp_ch.ready         = 1'b0;
        enq_depth            = 0;
        deq_depth            = 0;
        mismatch_count       = 0;
        quiet_cycles         = 0;
        stall_left           = 0;
        sender_gaps_on       = 1'b1;
        sink_gaps_on         = 1'b1;
        enq_pct              = 50;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row = directed_rows[r];
            want.dequeue_value = row.want_value;
            want.status        = row.want_status;
            for (int k = 0; k < row.reps; k++)
                send_request(row.op, row.value + k, row.has_want, want);
        end

        // Random requests in blocks that lean toward filling or draining, or stay balanced
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
            begin
                mode = $urandom_range(0, 2);
                enq_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
                sender_gaps_on = ($urandom_range(0, 3) != 0);
                sink_gaps_on   = ($urandom_range(0, 3) != 0);
            end
            if (i >= RANDOM_ITEMS - CALM_TAIL)
            begin
                sender_gaps_on = 1'b0;
                sink_gaps_on   = 1'b0;
            end
            // hold off new requests until every response is back
            if (i == PAUSE_AT)
            begin
                req_ch.valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            op = ($urandom_range(0, 99) < enq_pct) ? qts_pkg::FUNC_ENQ : qts_pkg::FUNC_DEQ;
            send_request(op, random_value(), 1'b0, want);
        end
        req_ch.valid <= 1'b0;

        // Drain outstanding responses, then watch for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_queue_from_two_stacks_unit: clean");
        else
            $display("tb_queue_from_two_stacks_unit: errors");
        $finish;
    end

endmodule
